### rtl/core/rbnh_pkg.sv
// shared types and constants for the ray / box nearest hit block
package rbnh_pkg;

	localparam int COORD_W   = 32;
	localparam int INV_W     = 48;
	localparam int CFG_W     = 48;
	localparam int CFG_IDX_W = 3;
	localparam int ID_BITS   = 16;
	localparam int DIST_W    = 32;
	localparam int LO_W      = 24;
	localparam int HI_W      = INV_W - LO_W;
	localparam int PROD_W    = COORD_W + LO_W;
	localparam int T_W       = PROD_W + 1;

	localparam logic signed [T_W-1:0] T_INF = {1'b0, {(T_W-1){1'b1}}};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ORIGIN_X,
		REG_ORIGIN_Y,
		REG_ORIGIN_Z,
		REG_INV_DIR_X,
		REG_INV_DIR_Y,
		REG_INV_DIR_Z,
		REG_PARALLEL_MASK
	} cfg_reg_t;

	typedef struct packed {
		logic signed [T_W-1:0] t_near;
		logic signed [T_W-1:0] t_far;
		logic                  reject;
	} slab_t;

	typedef struct packed {
		logic [ID_BITS-1:0] id;
		logic               last;
	} tag_t;

endpackage

### rtl/core/rbnh_slab.sv
// one axis of the slab test: deltas, split product, signed distance, ordering
module rbnh_slab (
	input  logic                                  clk,
	input  logic                                  en,
	input  logic signed [rbnh_pkg::COORD_W-1:0]   box_min,
	input  logic signed [rbnh_pkg::COORD_W-1:0]   box_max,
	input  logic signed [rbnh_pkg::COORD_W-1:0]   origin,
	input  logic signed [rbnh_pkg::INV_W-1:0]     inv_dir,
	input  logic                                  par,
	output rbnh_pkg::slab_t                       slab_s5
);

	localparam int CW = rbnh_pkg::COORD_W;
	localparam int PW = rbnh_pkg::PROD_W;
	localparam int TW = rbnh_pkg::T_W;
	localparam int LW = rbnh_pkg::LO_W;
	localparam int HW = rbnh_pkg::HI_W;

	logic [CW:0]                   dmin_a, dmin_b, dmax_a, dmax_b;
	logic [rbnh_pkg::INV_W-1:0]    inv_mag;
	logic                          inv_neg;

	logic [CW-1:0]                 ud_min_s2, ud_max_s2;
	logic [HW-1:0]                 hi_s2;
	logic [LW-1:0]                 lo_s2;
	logic                          neg_min_s2, neg_max_s2, par_s2, rej_s2;

	logic [PW-1:0]                 phi_min_s3, plo_min_s3, phi_max_s3, plo_max_s3;
	logic                          neg_min_s3, neg_max_s3, par_s3, rej_s3;

	logic [PW-1:0]                 mag_min, mag_max;
	logic signed [TW-1:0]          tm_min, tm_max;
	logic signed [TW-1:0]          t_min_s4, t_max_s4;
	logic                          par_s4, rej_s4;

	// stage 2: corner minus origin, both ways, magnitude by sign
	assign dmin_a  = {box_min[CW-1], box_min} - {origin[CW-1], origin};
	assign dmin_b  = {origin[CW-1], origin} - {box_min[CW-1], box_min};
	assign dmax_a  = {box_max[CW-1], box_max} - {origin[CW-1], origin};
	assign dmax_b  = {origin[CW-1], origin} - {box_max[CW-1], box_max};
	assign inv_neg = inv_dir[rbnh_pkg::INV_W-1];
	assign inv_mag = inv_neg ? (~inv_dir + 1'b1) : inv_dir;

	always_ff @(posedge clk) begin
		if (en) begin
			ud_min_s2  <= dmin_a[CW] ? dmin_b[CW-1:0] : dmin_a[CW-1:0];
			ud_max_s2  <= dmax_a[CW] ? dmax_b[CW-1:0] : dmax_a[CW-1:0];
			neg_min_s2 <= dmin_a[CW] ^ inv_neg;
			neg_max_s2 <= dmax_a[CW] ^ inv_neg;
			hi_s2      <= inv_mag[rbnh_pkg::INV_W-1:LW];
			lo_s2      <= inv_mag[LW-1:0];
			par_s2     <= par;
			rej_s2     <= par && (origin < box_min || origin > box_max);
		end
	end

	// stage 3: magnitude times high and low halves of the reciprocal
	always_ff @(posedge clk) begin
		if (en) begin
			phi_min_s3 <= PW'(ud_min_s2 * hi_s2);
			plo_min_s3 <= PW'(ud_min_s2 * lo_s2);
			phi_max_s3 <= PW'(ud_max_s2 * hi_s2);
			plo_max_s3 <= PW'(ud_max_s2 * lo_s2);
			neg_min_s3 <= neg_min_s2;
			neg_max_s3 <= neg_max_s2;
			par_s3     <= par_s2;
			rej_s3     <= rej_s2;
		end
	end

	// stage 4: recombine, truncate toward zero, apply sign
	assign mag_min = phi_min_s3 + {{LW{1'b0}}, plo_min_s3[PW-1:LW]};
	assign mag_max = phi_max_s3 + {{LW{1'b0}}, plo_max_s3[PW-1:LW]};
	assign tm_min  = {1'b0, mag_min};
	assign tm_max  = {1'b0, mag_max};

	always_ff @(posedge clk) begin
		if (en) begin
			t_min_s4 <= neg_min_s3 ? -tm_min : tm_min;
			t_max_s4 <= neg_max_s3 ? -tm_max : tm_max;
			par_s4   <= par_s3;
			rej_s4   <= rej_s3;
		end
	end

	// stage 5: order the pair, parallel axis leaves the interval open
	always_ff @(posedge clk) begin
		if (en) begin
			if (par_s4) begin
				slab_s5.t_near <= '0;
				slab_s5.t_far  <= rbnh_pkg::T_INF;
			end else if (t_min_s4 > t_max_s4) begin
				slab_s5.t_near <= t_max_s4;
				slab_s5.t_far  <= t_min_s4;
			end else begin
				slab_s5.t_near <= t_min_s4;
				slab_s5.t_far  <= t_max_s4;
			end
			slab_s5.reject <= rej_s4;
		end
	end

endmodule

### rtl/core/rbnh_best.sv
// running nearest hit and result register
module rbnh_best (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  take,
	input  logic signed [rbnh_pkg::T_W-1:0]       entry,
	input  logic signed [rbnh_pkg::T_W-1:0]       exit_t,
	input  logic                                  reject,
	input  rbnh_pkg::tag_t                        tag,
	input  logic                                  hit_ready,
	output logic                                  hit_valid,
	output logic                                  found,
	output logic [rbnh_pkg::ID_BITS-1:0]          nearest_id,
	output logic [rbnh_pkg::DIST_W-1:0]           nearest_distance
);

	localparam int TW = rbnh_pkg::T_W;
	localparam int DW = rbnh_pkg::DIST_W;

	logic                            any_q;
	logic [DW-1:0]                   best_dist_q;
	logic [rbnh_pkg::ID_BITS-1:0]    best_id_q;

	logic                            hit, upd, nb_any;
	logic [DW-1:0]                   sat_dist, nb_dist;
	logic [rbnh_pkg::ID_BITS-1:0]    nb_id;

	assign hit      = !reject && (exit_t >= entry) && !exit_t[TW-1];
	assign sat_dist = (|entry[TW-1:DW]) ? {DW{1'b1}} : entry[DW-1:0];
	assign upd      = hit && (!any_q || sat_dist < best_dist_q);
	assign nb_any   = any_q || hit;
	assign nb_dist  = upd ? sat_dist : best_dist_q;
	assign nb_id    = upd ? tag.id : best_id_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			any_q       <= 1'b0;
			best_dist_q <= '1;
			best_id_q   <= '0;
			hit_valid   <= 1'b0;
		end else begin
			if (hit_valid && hit_ready) begin
				hit_valid <= 1'b0;
			end
			if (take) begin
				if (tag.last) begin
					hit_valid   <= 1'b1;
					any_q       <= 1'b0;
					best_dist_q <= '1;
					best_id_q   <= '0;
				end else begin
					any_q       <= nb_any;
					best_dist_q <= nb_dist;
					best_id_q   <= nb_id;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && tag.last) begin
			found            <= nb_any;
			nearest_id       <= nb_any ? nb_id : '0;
			nearest_distance <= nb_dist;
		end
	end

	a_last_emits: assert property (@(posedge clk) disable iff (!arst_n)
		take && tag.last |=> hit_valid && !any_q && best_dist_q == '1 && best_id_q == '0)
		else $error("last item did not emit and clear");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		take && tag.last |-> !hit_valid || hit_ready)
		else $error("result overwritten before taken");

	a_none_found: assert property (@(posedge clk) disable iff (!arst_n)
		hit_valid && !found |-> nearest_id == '0 && nearest_distance == '1)
		else $error("empty result carries id or distance");

	a_best_only_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		take && !tag.last && any_q |=> best_dist_q <= $past(best_dist_q))
		else $error("kept distance grew");

endmodule

### rtl/core/ray_box_nearest_hit.sv
// top level: ray registers, box input register, three axis slabs, reduce, nearest hit
//
// One box is accepted per cycle while box_ready is high. The box marked last passes the
// input register, four stages of per-axis slab arithmetic (delta, split 32x24 products,
// recombine and sign, ordering), one stage that merges the axes into entry and exit,
// then the running-minimum update that writes the result register.
// The only feedback is the compare and update of the kept nearest hit, so boxes stream
// back to back. box_ready drops only while a last box waits at the end of the pipe
// behind a result that has not yet been taken. Ray registers may be written when no box
// is in flight; there is no clearing pass after reset.
module ray_box_nearest_hit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [rbnh_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [rbnh_pkg::CFG_W-1:0]            cfg_data,
	input  logic                                  box_valid,
	output logic                                  box_ready,
	input  logic signed [rbnh_pkg::COORD_W-1:0]   box_min_x,
	input  logic signed [rbnh_pkg::COORD_W-1:0]   box_min_y,
	input  logic signed [rbnh_pkg::COORD_W-1:0]   box_min_z,
	input  logic signed [rbnh_pkg::COORD_W-1:0]   box_max_x,
	input  logic signed [rbnh_pkg::COORD_W-1:0]   box_max_y,
	input  logic signed [rbnh_pkg::COORD_W-1:0]   box_max_z,
	input  logic [rbnh_pkg::ID_BITS-1:0]          box_id,
	input  logic                                  last_box,
	output logic                                  hit_valid,
	input  logic                                  hit_ready,
	output logic                                  found,
	output logic [rbnh_pkg::ID_BITS-1:0]          nearest_id,
	output logic [rbnh_pkg::DIST_W-1:0]           nearest_distance
);

	localparam int CW = rbnh_pkg::COORD_W;
	localparam int IW = rbnh_pkg::INV_W;
	localparam int TW = rbnh_pkg::T_W;

	logic signed [CW-1:0]   origin_x_q, origin_y_q, origin_z_q;
	logic signed [IW-1:0]   inv_dir_x_q, inv_dir_y_q, inv_dir_z_q;
	logic [2:0]             par_mask_q;

	logic                   adv;
	logic                   vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic signed [CW-1:0]   min_x_s1, min_y_s1, min_z_s1, max_x_s1, max_y_s1, max_z_s1;
	rbnh_pkg::tag_t         tag_s1, tag_s2, tag_s3, tag_s4, tag_s5, tag_s6;
	rbnh_pkg::slab_t        sx_s5, sy_s5, sz_s5;

	logic signed [TW-1:0]   nx, ny, nz, fx, fy, fz;
	logic signed [TW-1:0]   en_a, en_b, ex_a, ex_b;
	logic signed [TW-1:0]   entry_s6, exit_s6;
	logic                   rej_s6;

	// ray registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q  <= '0;
			origin_y_q  <= '0;
			origin_z_q  <= '0;
			inv_dir_x_q <= '0;
			inv_dir_y_q <= '0;
			inv_dir_z_q <= '0;
			par_mask_q  <= '0;
		end else if (cfg_we) begin
			unique case (rbnh_pkg::cfg_reg_t'(cfg_index))
				rbnh_pkg::REG_ORIGIN_X:      origin_x_q  <= cfg_data[CW-1:0];
				rbnh_pkg::REG_ORIGIN_Y:      origin_y_q  <= cfg_data[CW-1:0];
				rbnh_pkg::REG_ORIGIN_Z:      origin_z_q  <= cfg_data[CW-1:0];
				rbnh_pkg::REG_INV_DIR_X:     inv_dir_x_q <= cfg_data[IW-1:0];
				rbnh_pkg::REG_INV_DIR_Y:     inv_dir_y_q <= cfg_data[IW-1:0];
				rbnh_pkg::REG_INV_DIR_Z:     inv_dir_z_q <= cfg_data[IW-1:0];
				rbnh_pkg::REG_PARALLEL_MASK: par_mask_q  <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	// whole pipe holds only when a last item meets an untaken result
	assign adv       = !(vld_s6 && tag_s6.last && hit_valid && !hit_ready);
	assign box_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= box_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			min_x_s1 <= box_min_x;
			min_y_s1 <= box_min_y;
			min_z_s1 <= box_min_z;
			max_x_s1 <= box_max_x;
			max_y_s1 <= box_max_y;
			max_z_s1 <= box_max_z;
			tag_s1   <= '{id: box_id, last: last_box};
			tag_s2   <= tag_s1;
			tag_s3   <= tag_s2;
			tag_s4   <= tag_s3;
			tag_s5   <= tag_s4;
			tag_s6   <= tag_s5;
		end
	end

	rbnh_slab u_slab_x (
		.clk     (clk),
		.en      (adv),
		.box_min (min_x_s1),
		.box_max (max_x_s1),
		.origin  (origin_x_q),
		.inv_dir (inv_dir_x_q),
		.par     (par_mask_q[0]),
		.slab_s5 (sx_s5)
	);

	rbnh_slab u_slab_y (
		.clk     (clk),
		.en      (adv),
		.box_min (min_y_s1),
		.box_max (max_y_s1),
		.origin  (origin_y_q),
		.inv_dir (inv_dir_y_q),
		.par     (par_mask_q[1]),
		.slab_s5 (sy_s5)
	);

	rbnh_slab u_slab_z (
		.clk     (clk),
		.en      (adv),
		.box_min (min_z_s1),
		.box_max (max_z_s1),
		.origin  (origin_z_q),
		.inv_dir (inv_dir_z_q),
		.par     (par_mask_q[2]),
		.slab_s5 (sz_s5)
	);

	// merge axes: entry = max(0, nears), exit = min(fars)
	assign nx   = sx_s5.t_near;
	assign ny   = sy_s5.t_near;
	assign nz   = sz_s5.t_near;
	assign fx   = sx_s5.t_far;
	assign fy   = sy_s5.t_far;
	assign fz   = sz_s5.t_far;
	assign en_a = nx[TW-1] ? '0 : nx;
	assign en_b = (ny > nz) ? ny : nz;
	assign ex_a = (fx < fy) ? fx : fy;
	assign ex_b = fz;

	always_ff @(posedge clk) begin
		if (adv) begin
			entry_s6 <= (en_a > en_b) ? en_a : en_b;
			exit_s6  <= (ex_a < ex_b) ? ex_a : ex_b;
			rej_s6   <= sx_s5.reject || sy_s5.reject || sz_s5.reject;
		end
	end

	rbnh_best u_best (
		.clk              (clk),
		.arst_n           (arst_n),
		.take             (vld_s6 && adv),
		.entry            (entry_s6),
		.exit_t           (exit_s6),
		.reject           (rej_s6),
		.tag              (tag_s6),
		.hit_ready        (hit_ready),
		.hit_valid        (hit_valid),
		.found            (found),
		.nearest_id       (nearest_id),
		.nearest_distance (nearest_distance)
	);

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!box_ready |=> vld_s6 && tag_s6.last && $stable(entry_s6) && $stable(exit_s6))
		else $error("stalled last item moved");

	a_entry_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s6 |-> !entry_s6[TW-1])
		else $error("negative entry distance");

endmodule
